FILE: design/clt_pkg.sv
package clt_pkg;

    // one accepted byte causes at most four results
    localparam int SlotNum   = 4;
    localparam int SlotW     = $clog2(SlotNum);
    localparam int CntW      = $clog2(SlotNum + 1);
    localparam int FifoDepth = 4;

    localparam logic [1:0] KindStart = 2'd0;
    localparam logic [1:0] KindByte  = 2'd1;
    localparam logic [1:0] KindEnd   = 2'd2;
    localparam logic [1:0] KindLine  = 2'd3;

    localparam logic [1:0] QuoteNone   = 2'd0;
    localparam logic [1:0] QuoteSingle = 2'd1;
    localparam logic [1:0] QuoteDouble = 2'd2;

    // all results caused by one input byte
    typedef struct packed {
        logic [CntW-1:0]           cnt;
        logic [7:0]                arg_num;
        logic [1:0]                open_q;
        logic [SlotNum-1:0][1:0]   kind;
        logic [SlotNum-1:0][7:0]   data;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

FILE: design/command_line_tokenizer.sv
// channel  direction  handshake              payload
// config   in         i_cfg_we               i_cfg_wdata (max_args)
// bytes    in         push / full            i_in_byte
// results  out        empty / pop            o_kind, o_data_byte, o_arg_number,
//                                            o_open_quote, o_last
//
// one byte is taken per cycle while the result queue has room; the tokenizer
// state updates in that same cycle
// the results of one byte (up to four) leave at one per cycle while pop is held, so a byte with
// k results takes k transfers; FIFO_DEPTH bundles absorb bursts
// results pass through the registered result queue, so none appear in the cycle the byte is taken
// reset is synchronous: queue empty, tokenizer between arguments, limit zero
module command_line_tokenizer #(
    parameter int FIFO_DEPTH = clt_pkg::FifoDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_arg_number,
    output logic [1:0] o_open_quote,
    output logic       o_last
);
    import clt_pkg::*;

    t_bundle    w_wdata;
    t_bundle    w_head;
    t_fifo_stat w_stat;
    logic       w_wr;
    logic       w_rd;
    logic       w_take;

    assign full   = w_stat.full;
    assign w_take = push && !w_stat.full;

    clt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_byte      (i_in_byte),
        .o_wr        (w_wr),
        .o_bundle    (w_wdata)
    );

    clt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wdata),
        .i_rd    (w_rd),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    clt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_stat       (w_stat),
        .i_pop        (pop),
        .o_rd         (w_rd),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_arg_number (o_arg_number),
        .o_open_quote (o_open_quote),
        .o_last       (o_last)
    );

endmodule

FILE: design/clt_front.sv
module clt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output logic             o_wr,
    output clt_pkg::t_bundle o_bundle
);
    import clt_pkg::*;

    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSquote = 8'h27;
    localparam logic [7:0] ChDquote = 8'h22;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChSeven  = 8'h37;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChLowA   = 8'h61;
    localparam logic [7:0] ChLowF   = 8'h66;
    localparam logic [7:0] ChUpA    = 8'h41;
    localparam logic [7:0] ChUpF    = 8'h46;
    localparam logic [7:0] ChLowX   = 8'h78;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChCr     = 8'h0D;

    typedef enum logic [2:0] {
        ModeIdle = 3'b001,
        ModeArg  = 3'b010,
        ModeRaw  = 3'b100
    } t_mode;

    typedef enum logic [4:0] {
        EscNone = 5'b00001,
        EscOut  = 5'b00010,
        EscIn   = 5'b00100,
        EscOct  = 5'b01000,
        EscHex  = 5'b10000
    } t_esc;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == ChSpace) || (b inside {[ChTab:ChCr]});
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b inside {[ChZero:ChNine]}) begin
            d = b - ChZero;
            return {1'b1, d[3:0]};
        end
        if (b inside {[ChLowA:ChLowF]}) begin
            d = b - ChLowA + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (b inside {[ChUpA:ChUpF]}) begin
            d = b - ChUpA + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    function automatic t_bundle put(input t_bundle bd, input logic [1:0] k,
                                    input logic [7:0] d);
        t_bundle res;
        res = bd;
        res.kind[bd.cnt[SlotW-1:0]] = k;
        res.data[bd.cnt[SlotW-1:0]] = d;
        res.cnt = bd.cnt + CntW'(1);
        return res;
    endfunction

    t_mode      r_mode, n_mode;
    t_esc       r_esc, n_esc;
    logic [1:0] r_quote, n_quote;
    logic [1:0] r_dc, n_dc;
    logic [7:0] r_ev, n_ev;
    logic [7:0] r_args, n_args;
    logic [7:0] r_max;

    t_bundle    v_bd;
    logic       v_end;
    logic       v_plain;
    logic       v_raw;
    logic [4:0] v_hex;
    logic [7:0] v_q;

    always_comb begin
        n_mode  = r_mode;
        n_esc   = r_esc;
        n_quote = r_quote;
        n_dc    = r_dc;
        n_ev    = r_ev;
        n_args  = r_args;
        v_bd    = '0;
        v_end   = 1'b0;
        v_plain = 1'b0;
        v_raw   = 1'b0;
        v_hex   = hex_digit(i_byte);
        v_q     = (r_quote == QuoteSingle) ? ChSquote :
                  (r_quote == QuoteDouble) ? ChDquote : 8'h00;

        case (r_mode)
            ModeRaw: begin
                if (i_byte == 8'h00) v_end = 1'b1;
                else v_bd = put(v_bd, KindByte, i_byte);
            end
            ModeArg: begin
                case (r_esc)
                    EscOut: begin
                        n_esc = EscNone;
                        if (i_byte == 8'h00) v_end = 1'b1;
                        else v_bd = put(v_bd, KindByte, i_byte);
                    end
                    EscIn: begin
                        n_esc = EscNone;
                        if (v_q != 8'h00 && i_byte == v_q) begin
                            v_bd = put(v_bd, KindByte, v_q);
                        end else if (i_byte == ChZero || i_byte == ChLowX) begin
                            n_esc = (i_byte == ChZero) ? EscOct : EscHex;
                            n_dc  = 2'd0;
                            n_ev  = 8'h00;
                        end else begin
                            v_bd    = put(v_bd, KindByte, ChBslash);
                            v_plain = 1'b1;
                        end
                    end
                    EscOct: begin
                        if (i_byte inside {[ChZero:ChSeven]} && r_dc != 2'd3) begin
                            n_ev = {r_ev[4:0], i_byte[2:0]};
                            n_dc = r_dc + 2'd1;
                            if (n_dc == 2'd3) begin
                                v_bd  = put(v_bd, KindByte, n_ev);
                                n_esc = EscNone;
                            end
                        end else begin
                            n_esc = EscNone;
                            if (r_dc == 2'd0) begin
                                v_bd = put(v_bd, KindByte, ChBslash);
                                v_bd = put(v_bd, KindByte, ChZero);
                            end else begin
                                v_bd = put(v_bd, KindByte, r_ev);
                            end
                            v_plain = 1'b1;
                        end
                    end
                    EscHex: begin
                        if (v_hex[4] && r_dc < 2'd2) begin
                            n_ev = {r_ev[3:0], v_hex[3:0]};
                            n_dc = r_dc + 2'd1;
                            if (n_dc == 2'd2) begin
                                v_bd  = put(v_bd, KindByte, n_ev);
                                n_esc = EscNone;
                            end
                        end else begin
                            n_esc = EscNone;
                            if (r_dc == 2'd0) begin
                                v_bd = put(v_bd, KindByte, ChBslash);
                                v_bd = put(v_bd, KindByte, ChLowX);
                            end else begin
                                v_bd = put(v_bd, KindByte, r_ev);
                            end
                            v_plain = 1'b1;
                        end
                    end
                    default: begin
                        n_esc   = EscNone;
                        v_plain = 1'b1;
                    end
                endcase
            end
            default: begin
                n_mode = ModeIdle;
                if (i_byte == 8'h00) begin
                    v_end = 1'b1;
                end else if (!is_blank(i_byte)) begin
                    if (r_args != 8'hFF) begin
                        n_args = r_args + 8'd1;
                        v_raw  = (r_max != 8'h00) && (n_args == r_max);
                    end
                    v_bd = put(v_bd, KindStart, 8'h00);
                    if (v_raw) begin
                        n_mode = ModeRaw;
                        v_bd   = put(v_bd, KindByte, i_byte);
                    end else begin
                        n_mode  = ModeArg;
                        n_quote = QuoteNone;
                        n_esc   = EscNone;
                        v_plain = 1'b1;
                    end
                end
            end
        endcase

        // ordinary byte inside an argument, after any escape output
        if (v_plain) begin
            if (i_byte == 8'h00) begin
                v_end = 1'b1;
            end else if (n_quote == QuoteNone) begin
                if (i_byte == ChBslash) begin
                    n_esc = EscOut;
                end else if (i_byte == ChSquote) begin
                    n_quote = QuoteSingle;
                end else if (i_byte == ChDquote) begin
                    n_quote = QuoteDouble;
                end else if (is_blank(i_byte)) begin
                    v_bd   = put(v_bd, KindEnd, 8'h00);
                    n_mode = ModeIdle;
                end else begin
                    v_bd = put(v_bd, KindByte, i_byte);
                end
            end else begin
                if ((n_quote == QuoteSingle && i_byte == ChSquote) ||
                    (n_quote == QuoteDouble && i_byte == ChDquote)) begin
                    n_quote = QuoteNone;
                end else if (i_byte == ChBslash) begin
                    n_esc = EscIn;
                end else begin
                    v_bd = put(v_bd, KindByte, i_byte);
                end
            end
        end

        v_bd.arg_num = n_args;

        if (v_end) begin
            if (n_mode != ModeIdle) v_bd = put(v_bd, KindEnd, 8'h00);
            v_bd = put(v_bd, KindLine, 8'h00);
            v_bd.open_q = (n_mode == ModeArg) ? n_quote : QuoteNone;
            n_mode  = ModeIdle;
            n_quote = QuoteNone;
            n_esc   = EscNone;
            n_dc    = 2'd0;
            n_ev    = 8'h00;
            n_args  = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ModeIdle;
            r_esc   <= EscNone;
            r_quote <= QuoteNone;
            r_dc    <= 2'd0;
            r_ev    <= 8'h00;
            r_args  <= 8'h00;
            r_max   <= 8'h00;
        end else begin
            if (i_cfg_we) r_max <= i_cfg_wdata;
            if (i_take) begin
                r_mode  <= n_mode;
                r_esc   <= n_esc;
                r_quote <= n_quote;
                r_dc    <= n_dc;
                r_ev    <= n_ev;
                r_args  <= n_args;
            end
        end
    end

    assign o_wr     = i_take && (v_bd.cnt != '0);
    assign o_bundle = v_bd;

endmodule

FILE: design/clt_fifo.sv
module clt_fifo #(
    parameter int DEPTH = clt_pkg::FifoDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  clt_pkg::t_bundle    i_wdata,
    input  logic                i_rd,
    output clt_pkg::t_bundle    o_head,
    output clt_pkg::t_fifo_stat o_stat
);
    import clt_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LvlW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PtrW-1:0] r_wp, n_wp;
    logic [PtrW-1:0] r_rp, n_rp;
    logic [LvlW-1:0] r_lvl, n_lvl;
    logic            v_wr_ok;
    logic            v_rd_ok;

    assign o_stat.full  = (r_lvl == LvlW'(DEPTH));
    assign o_stat.empty = (r_lvl == '0);
    assign v_wr_ok      = i_wr && !o_stat.full;
    assign v_rd_ok      = i_rd && !o_stat.empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_lvl = r_lvl;
        if (v_wr_ok) n_wp = (r_wp == PtrW'(DEPTH - 1)) ? '0 : r_wp + PtrW'(1);
        if (v_rd_ok) n_rp = (r_rp == PtrW'(DEPTH - 1)) ? '0 : r_rp + PtrW'(1);
        if (v_wr_ok && !v_rd_ok) n_lvl = r_lvl + LvlW'(1);
        if (!v_wr_ok && v_rd_ok) n_lvl = r_lvl - LvlW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_lvl <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_wr_ok) r_mem[r_wp] <= i_wdata;
    end

    assign o_head = r_mem[r_rp];

endmodule

FILE: design/clt_back.sv
module clt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clt_pkg::t_bundle    i_head,
    input  clt_pkg::t_fifo_stat i_stat,
    input  logic                i_pop,
    output logic                o_rd,
    output logic                o_empty,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_data_byte,
    output logic [7:0]          o_arg_number,
    output logic [1:0]          o_open_quote,
    output logic                o_last
);
    import clt_pkg::*;

    logic [SlotW-1:0] r_slot, n_slot;
    logic             v_last;
    logic             v_take;

    assign v_last = (CntW'(r_slot) + CntW'(1)) == i_head.cnt;
    assign v_take = i_pop && !i_stat.empty;

    always_comb begin
        n_slot = r_slot;
        if (v_take) n_slot = v_last ? '0 : r_slot + SlotW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    // the bundle leaves the queue with the transfer of its last result
    assign o_rd         = v_take && v_last;
    assign o_empty      = i_stat.empty;
    assign o_kind       = i_head.kind[r_slot];
    assign o_data_byte  = i_head.data[r_slot];
    assign o_arg_number = i_head.arg_num;
    assign o_open_quote = (i_head.kind[r_slot] == KindLine) ? i_head.open_q : QuoteNone;
    assign o_last       = v_last;

endmodule

FILE: design/clt_checker.sv
module clt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_kind,
    input logic [7:0] o_data_byte,
    input logic [7:0] o_arg_number,
    input logic [1:0] o_open_quote,
    input logic       o_last
);
    import clt_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not cleared by reset");

    a_data_only_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind != KindByte |-> o_data_byte == 8'h00)
        else $error("data byte set on a result that is not an argument byte");

    a_quote_only_on_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind != KindLine |-> o_open_quote == QuoteNone)
        else $error("open quote reported before line end");

    a_line_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KindLine |-> o_last)
        else $error("line end not the final result of its byte");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kind) && $stable(o_data_byte) &&
                           $stable(o_arg_number) && $stable(o_open_quote) &&
                           $stable(o_last))
        else $error("waiting result changed before transfer");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_kind       (o_kind),
    .o_data_byte  (o_data_byte),
    .o_arg_number (o_arg_number),
    .o_open_quote (o_open_quote),
    .o_last       (o_last)
);

FILE: tb/tb_command_line_tokenizer.sv
module tb_command_line_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import clt_pkg::*;

    localparam int StallLimit = 2000;

    localparam logic [7:0] ChNul     = 8'h00;
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChCr      = 8'h0D;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChDquote  = 8'h22;
    localparam logic [7:0] ChSquote  = 8'h27;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChOne     = 8'h31;
    localparam logic [7:0] ChSeven   = 8'h37;
    localparam logic [7:0] ChEight   = 8'h38;
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChUpA     = 8'h41;
    localparam logic [7:0] ChUpF     = 8'h46;
    localparam logic [7:0] ChBslash  = 8'h5C;
    localparam logic [7:0] ChLowA    = 8'h61;
    localparam logic [7:0] ChLowF    = 8'h66;
    localparam logic [7:0] ChLowX    = 8'h78;

    typedef enum logic [1:0] {ScanGap, ScanArg, ScanRaw} t_scan;
    typedef enum logic [2:0] {EscIdle, EscBare, EscQuoted, EscOct, EscHex} t_esc;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] argn;
        logic [1:0] oq;
        logic       last;
    } t_token;

    // one directed byte; n_typed of zero leaves the expectation to the predictor
    typedef struct packed {
        logic [7:0] chr;
        logic [1:0] n_typed;
        t_token     t0;
        t_token     t1;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       empty;
    logic       pop;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;
    logic [7:0] o_arg_number;
    logic [1:0] o_open_quote;
    logic       o_last;

    command_line_tokenizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_arg_number (o_arg_number),
        .o_open_quote (o_open_quote),
        .o_last       (o_last)
    );

    // tokenizer state as the predictor sees it
    logic [7:0] arg_limit;
    t_scan      scan;
    logic [1:0] quote;
    t_esc       esc;
    logic [1:0] ndig;
    logic [7:0] acc;
    logic [7:0] started;

    t_token     byte_tokens[$];
    t_token     pending_tokens[$];
    logic [7:0] stim_q[$];
    t_row       dir_rows[$];

    int bad_count = 0;
    int tx_count  = 0;
    bit calm_tx   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_line();
        scan    = ScanGap;
        quote   = QuoteNone;
        esc     = EscIdle;
        ndig    = '0;
        acc     = '0;
        started = '0;
    endfunction

    function automatic void put(logic [1:0] k, logic [7:0] d, logic [1:0] q);
        byte_tokens.push_back('{kind: k, data: d, argn: started, oq: q, last: 1'b0});
    endfunction

    function automatic bit blank_chr(logic [7:0] b);
        return b == ChSpace || (b >= ChTab && b <= ChCr);
    endfunction

    function automatic logic [7:0] open_char();
        if (quote == QuoteSingle) return ChSquote;
        if (quote == QuoteDouble) return ChDquote;
        return ChNul;
    endfunction

    function automatic int hex_val(logic [7:0] b);
        if (b >= ChZero && b <= ChNine) return int'(b - ChZero);
        if (b >= ChLowA && b <= ChLowF) return int'(b - ChLowA) + 10;
        if (b >= ChUpA && b <= ChUpF) return int'(b - ChUpA) + 10;
        return -1;
    endfunction

    function automatic void finish_line();
        if (scan != ScanGap) put(KindEnd, 8'd0, QuoteNone);
        put(KindLine, 8'd0, (scan == ScanArg) ? quote : QuoteNone);
        clear_line();
    endfunction

    function automatic void plain_chr(logic [7:0] b);
        if (b == ChNul) begin
            finish_line();
        end else if (quote == QuoteNone) begin
            if (b == ChBslash) esc = EscBare;
            else if (b == ChSquote) quote = QuoteSingle;
            else if (b == ChDquote) quote = QuoteDouble;
            else if (blank_chr(b)) begin
                put(KindEnd, 8'd0, QuoteNone);
                scan = ScanGap;
            end else put(KindByte, b, QuoteNone);
        end else begin
            if (b == open_char()) quote = QuoteNone;
            else if (b == ChBslash) esc = EscQuoted;
            else put(KindByte, b, QuoteNone);
        end
    endfunction

    // a non-digit closes an escape: flush what was collected, then handle it as usual
    function automatic void flush_escape(logic [7:0] b, logic [7:0] lead);
        esc = EscIdle;
        if (ndig == 0) begin
            put(KindByte, ChBslash, QuoteNone);
            put(KindByte, lead, QuoteNone);
        end else put(KindByte, acc, QuoteNone);
        plain_chr(b);
    endfunction

    function automatic void arg_chr(logic [7:0] b);
        logic [7:0] q;
        int         h;
        case (esc)
            EscBare: begin
                esc = EscIdle;
                if (b == ChNul) finish_line();
                else put(KindByte, b, QuoteNone);
            end
            EscQuoted: begin
                esc = EscIdle;
                q = open_char();
                if (q != ChNul && b == q) begin
                    put(KindByte, q, QuoteNone);
                end else if (b == ChZero || b == ChLowX) begin
                    esc  = (b == ChZero) ? EscOct : EscHex;
                    ndig = '0;
                    acc  = '0;
                end else begin
                    put(KindByte, ChBslash, QuoteNone);
                    plain_chr(b);
                end
            end
            EscOct: begin
                if (b >= ChZero && b <= ChSeven && ndig < 3) begin
                    acc  = {acc[4:0], b[2:0]};
                    ndig = ndig + 1'b1;
                    if (ndig == 3) begin
                        put(KindByte, acc, QuoteNone);
                        esc = EscIdle;
                    end
                end else flush_escape(b, ChZero);
            end
            EscHex: begin
                h = hex_val(b);
                if (h >= 0 && ndig < 2) begin
                    acc  = {acc[3:0], h[3:0]};
                    ndig = ndig + 1'b1;
                    if (ndig == 2) begin
                        put(KindByte, acc, QuoteNone);
                        esc = EscIdle;
                    end
                end else flush_escape(b, ChLowX);
            end
            default: begin
                esc = EscIdle;
                plain_chr(b);
            end
        endcase
    endfunction

    // results that one accepted byte causes, left in byte_tokens
    function automatic void tokenize_byte(logic [7:0] b);
        bit to_raw;
        byte_tokens.delete();
        if (scan == ScanRaw) begin
            if (b == ChNul) finish_line();
            else put(KindByte, b, QuoteNone);
        end else if (scan == ScanArg) begin
            arg_chr(b);
        end else if (b == ChNul) begin
            finish_line();
        end else if (!blank_chr(b)) begin
            to_raw = 1'b0;
            // a saturated count never reaches the limit again
            if (started != 8'd255) begin
                started = started + 1'b1;
                to_raw  = (arg_limit != 8'd0 && started == arg_limit);
            end
            put(KindStart, 8'd0, QuoteNone);
            if (to_raw) begin
                scan = ScanRaw;
                put(KindByte, b, QuoteNone);
            end else begin
                scan  = ScanArg;
                quote = QuoteNone;
                esc   = EscIdle;
                plain_chr(b);
            end
        end
        if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic t_token tk(logic [1:0] k, logic [7:0] d, logic [7:0] n,
                                  logic [1:0] q, logic l);
        return '{kind: k, data: d, argn: n, oq: q, last: l};
    endfunction

    function automatic t_row pr(logic [7:0] c);
        return '{chr: c, n_typed: 2'd0, t0: '0, t1: '0};
    endfunction

    function automatic t_row tr(logic [7:0] c, t_token a, t_token b);
        return '{chr: c, n_typed: 2'd2, t0: a, t1: b};
    endfunction

    // ---------------- line generator ----------------

    function automatic logic [7:0] word_chr();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (blank_chr(b) || b == ChSquote || b == ChDquote || b == ChBslash);
        return b;
    endfunction

    function automatic logic [7:0] blank_code();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? ChSpace : ChTab + 8'(r);
    endfunction

    function automatic logic [7:0] hex_chr();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return ChZero + 8'(r);
        if (r < 16) return ChLowA + 8'(r - 10);
        return ChUpA + 8'(r - 16);
    endfunction

    function automatic void add_escape(logic [7:0] q);
        int n;
        stim_q.push_back(ChBslash);
        case ($urandom_range(0, 7))
            0: stim_q.push_back(q);
            1: begin
                stim_q.push_back(ChZero);
                n = $urandom_range(1, 4);
                repeat (n) stim_q.push_back(ChZero + 8'($urandom_range(0, 7)));
            end
            2: begin
                stim_q.push_back(ChLowX);
                n = $urandom_range(1, 3);
                repeat (n) stim_q.push_back(hex_chr());
            end
            3: stim_q.push_back(ChLowX);
            4: stim_q.push_back(ChZero);
            5: repeat (4) stim_q.push_back(ChZero);
            6: stim_q.push_back(word_chr());
            default: stim_q.push_back((q == ChSquote) ? ChDquote : ChBslash);
        endcase
    endfunction

    function automatic void add_quoted(bit closed);
        logic [7:0] q;
        int         n;
        q = $urandom_range(0, 1) ? ChSquote : ChDquote;
        stim_q.push_back(q);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0, 1: stim_q.push_back(word_chr());
                2: add_escape(q);
                default: stim_q.push_back(blank_code());
            endcase
        end
        if (closed) stim_q.push_back(q);
    endfunction

    function automatic void add_arg();
        int parts;
        parts = $urandom_range(1, 3);
        for (int i = 0; i < parts; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: repeat ($urandom_range(1, 3)) stim_q.push_back(word_chr());
                4: begin
                    stim_q.push_back(ChBslash);
                    stim_q.push_back(8'($urandom_range(1, 255)));
                end
                9: stim_q.push_back(8'($urandom_range(1, 255)));
                default: add_quoted($urandom_range(0, 9) != 0);
            endcase
        end
    endfunction

    function automatic void add_line();
        int n;
        if ($urandom_range(0, 9) == 0) begin
            // noise, zero bytes included
            repeat ($urandom_range(1, 8)) stim_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0) stim_q.push_back(blank_code());
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                if (i > 0) repeat ($urandom_range(1, 2)) stim_q.push_back(blank_code());
                add_arg();
            end
            case ($urandom_range(0, 7))
                0: stim_q.push_back(ChBslash);
                1: begin
                    // line ends inside a quoted escape
                    stim_q.push_back($urandom_range(0, 1) ? ChSquote : ChDquote);
                    stim_q.push_back(word_chr());
                    stim_q.push_back(ChBslash);
                    case ($urandom_range(0, 3))
                        0: ;
                        1: stim_q.push_back(ChZero);
                        2: begin
                            stim_q.push_back(ChZero);
                            repeat ($urandom_range(1, 2))
                                stim_q.push_back(ChZero + 8'($urandom_range(0, 7)));
                        end
                        default: begin
                            stim_q.push_back(ChLowX);
                            stim_q.push_back(hex_chr());
                        end
                    endcase
                end
                2: stim_q.push_back(blank_code());
                default: ;
            endcase
        end
        stim_q.push_back(ChNul);
    endfunction

    // ---------------- drivers ----------------

    // the idle gap comes before the byte, so push gets one assignment per edge
    task automatic send_byte(input logic [7:0] b, input logic [1:0] n_typed,
                             input t_token t0, input t_token t1);
        int gap;
        gap = calm_tx ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
        tokenize_byte(b);
        if (n_typed != 0) begin
            pending_tokens.push_back(t0);
            if (n_typed > 1) pending_tokens.push_back(t1);
        end else begin
            foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
        end
        tx_count++;
        if (tx_count % 40 == 0) calm_tx = ($urandom_range(0, 3) == 0);
    endtask

    // a byte may cause no result, so let the block settle after the last expected result is taken
    task automatic wait_idle(input int settle);
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        wait_idle(4);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        arg_limit = v;
    endtask

    task automatic run_phase(input logic [7:0] v, input int n_items, input bit crowd);
        set_limit(v);
        stim_q.delete();
        if (crowd) begin
            // several arguments started on a line left open, so the next limit applies mid-line
            repeat (8) begin
                stim_q.push_back(word_chr());
                stim_q.push_back(blank_code());
            end
        end else begin
            while (stim_q.size() < n_items) add_line();
            // sometimes stop mid-line so the limit changes inside a line
            if ($urandom_range(0, 2) == 0) void'(stim_q.pop_back());
        end
        foreach (stim_q[i]) send_byte(stim_q[i], 2'd0, '0, '0);
        push <= 1'b0;
    endtask

    // ---------------- result side ----------------

    task automatic check_token();
        t_token got;
        t_token want;
        got = '{kind: o_kind, data: o_data_byte, argn: o_arg_number,
                oq: o_open_quote, last: o_last};
        if (pending_tokens.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
                $display("unexpected result: kind=%0d data=%02h arg=%0d quote=%0d last=%0d",
                         got.kind, got.data, got.argn, got.oq, got.last);
        end else begin
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind || got.data !== want.data || got.argn !== want.argn
                    || got.oq !== want.oq || got.last !== want.last) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("mismatch: expected kind=%0d data=%02h arg=%0d quote=%0d last=%0d,",
                             want.kind, want.data, want.argn, want.oq, want.last,
                             " got kind=%0d data=%02h arg=%0d quote=%0d last=%0d",
                             got.kind, got.data, got.argn, got.oq, got.last);
            end
        end
    endtask

    initial begin
        int  hold_left;
        int  rx_gap;
        int  popped;
        int  cyc;
        bit  calm_rx;
        hold_left = 0;
        rx_gap    = 0;
        popped    = 0;
        cyc       = 0;
        calm_rx   = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (i_rst_n && pop && !empty) begin
                check_token();
                popped++;
                // long hold while the sender keeps offering bytes
                if (popped == 60 || popped == 200) hold_left = 150;
            end
            if (cyc % 128 == 0) calm_rx = ($urandom_range(0, 3) == 0);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!calm_rx) rx_gap = pick_gap();
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        @(posedge i_rst_n);
        while (idle < StallLimit) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) idle = 0;
            else idle++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        push        <= 1'b0;
        i_in_byte   <= 8'd0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 8'd0;
        i_rst_n     <= 1'b0;
        arg_limit = 8'd0;
        clear_line();

        dir_rows = '{
            tr(ChLowA, tk(KindStart, 8'd0, 8'd1, QuoteNone, 1'b0),
                       tk(KindByte, ChLowA, 8'd1, QuoteNone, 1'b1)),
            tr(ChNul,  tk(KindEnd, 8'd0, 8'd1, QuoteNone, 1'b0),
                       tk(KindLine, 8'd0, 8'd1, QuoteNone, 1'b1)),
            tr(8'hFF,  tk(KindStart, 8'd0, 8'd1, QuoteNone, 1'b0),
                       tk(KindByte, 8'hFF, 8'd1, QuoteNone, 1'b1)),
            pr(ChTab),
            // quote escape inside single quotes
            pr(ChSquote), pr(ChBslash), pr(ChSquote),
            // three-digit octal escape
            pr(ChBslash), pr(ChZero), pr(ChOne), pr(ChSeven), pr(ChSeven),
            // two-digit hex escape, both cases
            pr(ChBslash), pr(ChLowX), pr(ChUpF), pr(ChLowF),
            // octal escape with no digit, closed by a non-digit
            pr(ChBslash), pr(ChZero), pr(ChEight),
            pr(ChSquote), pr(ChSpace),
            // trailing backslash outside quotes is dropped
            pr(ChBslash),
            tr(ChNul,  tk(KindEnd, 8'd0, 8'd3, QuoteNone, 1'b0),
                       tk(KindLine, 8'd0, 8'd3, QuoteNone, 1'b1)),
            // empty hex escape in an open double quote at line end
            pr(ChDquote), pr(ChBslash), pr(ChLowX), pr(ChNul)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].chr, dir_rows[i].n_typed, dir_rows[i].t0, dir_rows[i].t1);
        push <= 1'b0;

        run_phase(8'd0, 0, 1'b1);
        run_phase(8'd255, 40, 1'b0);
        run_phase(8'd1, 40, 1'b0);
        run_phase(8'd2, 40, 1'b0);
        run_phase(8'd3, 40, 1'b0);
        run_phase(8'($urandom_range(0, 6)), 40, 1'b0);
        run_phase(8'd0, 40, 1'b0);

        wait_idle(20);
        if (bad_count == 0 && pending_tokens.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/clt_pkg.sv
design/clt_front.sv
design/clt_fifo.sv
design/clt_back.sv
design/command_line_tokenizer.sv
design/clt_checker.sv
tb/tb_command_line_tokenizer.sv
